/* hw/rtl/met_pkg.sv */
// Shared types, register codes and reset constants for the motion event tracker.
package met_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_DATA_W-1:0] DEBOUNCE_RESET = 16'd30;
    localparam logic [CFG_DATA_W-1:0] HOLDOFF_RESET  = 16'd2500;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE = 1'b0,
        CFG_HOLDOFF  = 1'b1
    } cfg_index_t;

    typedef enum logic {
        MODE_SAMPLE      = 1'b0,
        MODE_CLEAR_STATS = 1'b1
    } mode_t;

    typedef struct packed {
        logic        mode;
        logic        raw_level;
        logic [31:0] now_ms;
    } sample_t;

    typedef struct packed {
        logic        motion;
        logic        started;
        logic        ended;
        logic [31:0] last_span_ms;
        logic [31:0] event_total;
        logic [31:0] motion_sum_ms;
        logic [31:0] idle_sum_ms;
        logic [31:0] active_span_ms;
    } result_t;

endpackage

/* hw/rtl/met_step.sv */
// Tracker state, configuration registers and the combinational update for one word.
module met_step
    import met_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  advance,
    input  sample_t               word,
    output result_t               result
);

    logic [CFG_DATA_W-1:0] debounce_ms_reg;
    logic [CFG_DATA_W-1:0] holdoff_ms_reg;

    logic        stable_level_reg,  stable_level_next;
    logic [31:0] change_mark_reg,   change_mark_next;
    logic        accepted_reg,      accepted_next;
    logic [31:0] event_counter_reg, event_counter_next;
    logic [31:0] period_start_reg,  period_start_next;
    logic [31:0] holdoff_until_reg, holdoff_until_next;
    logic [31:0] motion_accum_reg,  motion_accum_next;
    logic [31:0] idle_accum_reg,    idle_accum_next;
    logic [31:0] current_span_reg,  current_span_next;

    logic        differs;
    logic        settle;
    logic        level;
    logic        rise;
    logic        hold_ok;
    logic        start;
    logic        fall;
    logic [31:0] elapsed;
    logic [31:0] span_raw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ms_reg <= DEBOUNCE_RESET;
            holdoff_ms_reg  <= HOLDOFF_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_DEBOUNCE: debounce_ms_reg <= cfg_data;
                CFG_HOLDOFF:  holdoff_ms_reg  <= cfg_data;
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        differs  = word.raw_level != stable_level_reg;
        elapsed  = word.now_ms - change_mark_reg;
        settle   = differs && (elapsed >= {16'd0, debounce_ms_reg});
        level    = settle ? word.raw_level : stable_level_reg;
        rise     = level && !accepted_reg;
        hold_ok  = word.now_ms >= holdoff_until_reg;
        start    = rise && hold_ok;
        // A suppressed rise leaves the accepted level low so it is retried later.
        fall     = !level && accepted_reg;
        span_raw = word.now_ms - period_start_reg;

        stable_level_next  = stable_level_reg;
        change_mark_next   = change_mark_reg;
        accepted_next      = accepted_reg;
        event_counter_next = event_counter_reg;
        period_start_next  = period_start_reg;
        holdoff_until_next = holdoff_until_reg;
        motion_accum_next  = motion_accum_reg;
        idle_accum_next    = idle_accum_reg;
        current_span_next  = current_span_reg;

        result.motion       = accepted_reg;
        result.started      = 1'b0;
        result.ended        = 1'b0;
        result.last_span_ms = 32'd0;

        if (word.mode == MODE_CLEAR_STATS)
        begin
            event_counter_next = 32'd0;
            motion_accum_next  = 32'd0;
            idle_accum_next    = 32'd0;
        end
        else
        begin
            stable_level_next = level;
            if (!differs || settle)
            begin
                change_mark_next = word.now_ms;
            end
            accepted_next = rise ? hold_ok : level;
            if (start)
            begin
                event_counter_next = event_counter_reg + 32'd1;
                idle_accum_next    = idle_accum_reg + span_raw;
                period_start_next  = word.now_ms;
            end
            if (fall)
            begin
                motion_accum_next  = motion_accum_reg + span_raw;
                holdoff_until_next = word.now_ms + {16'd0, holdoff_ms_reg};
                period_start_next  = word.now_ms;
            end
            if (accepted_next)
            begin
                current_span_next = start ? 32'd0 : span_raw;
            end
            result.motion       = accepted_next;
            result.started      = start;
            result.ended        = fall;
            result.last_span_ms = (start || fall) ? span_raw : 32'd0;
        end

        result.event_total    = event_counter_next;
        result.motion_sum_ms  = motion_accum_next;
        result.idle_sum_ms    = idle_accum_next;
        result.active_span_ms = current_span_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_level_reg  <= 1'b0;
            change_mark_reg   <= 32'd0;
            accepted_reg      <= 1'b0;
            event_counter_reg <= 32'd0;
            period_start_reg  <= 32'd0;
            holdoff_until_reg <= 32'd0;
            motion_accum_reg  <= 32'd0;
            idle_accum_reg    <= 32'd0;
            current_span_reg  <= 32'd0;
        end
        else if (advance)
        begin
            stable_level_reg  <= stable_level_next;
            change_mark_reg   <= change_mark_next;
            accepted_reg      <= accepted_next;
            event_counter_reg <= event_counter_next;
            period_start_reg  <= period_start_next;
            holdoff_until_reg <= holdoff_until_next;
            motion_accum_reg  <= motion_accum_next;
            idle_accum_reg    <= idle_accum_next;
            current_span_reg  <= current_span_next;
        end
    end

    // A counted start always restarts the active span from zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && result.started |=> current_span_reg == 32'd0)
        else $error("active span not cleared on start");

    // Hold-off deadline moves only when motion ends.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && !result.ended |=> $stable(holdoff_until_reg))
        else $error("hold-off deadline moved without a falling edge");

    // The stored accepted level follows the reported motion flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> accepted_reg == $past(result.motion))
        else $error("accepted level differs from reported motion");

endmodule

/* hw/rtl/motion_event_tracker_unit.sv */
// The result register takes the step result for the word in the input register when the step advances.
// Throughput: one word per cycle while the result is not stalled; the state update is one
// compare-and-add pass between the input register and the result register.
// A stalled result holds the pipe; the input register still takes a word while
// it holds no word, or the result register is empty or being drained.
// Reset (rst_n, asynchronous): pipe empty, tracker state zero, debounce 30 ms, hold-off 2500 ms.
module motion_event_tracker_unit
    import met_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  sample_valid,
    output logic                  sample_stall,
    input  sample_t               sample,
    output logic                  result_valid,
    input  logic                  result_stall,
    output result_t               result
);

    logic    in_valid_reg;
    sample_t in_word_reg;
    logic    out_valid_reg;
    result_t out_word_reg;
    result_t step_result;
    logic    advance;

    assign advance      = in_valid_reg && (!out_valid_reg || !result_stall);
    assign sample_stall = in_valid_reg && !advance;
    assign result_valid = out_valid_reg;
    assign result       = out_word_reg;

    met_step u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (advance),
        .word      (in_word_reg),
        .result    (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!sample_stall)
            begin
                in_valid_reg <= sample_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_valid && !sample_stall)
        begin
            in_word_reg <= sample;
        end
        if (advance)
        begin
            out_word_reg <= step_result;
        end
    end

    // A word cannot both start and end motion.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(result.started && result.ended))
        else $error("start and end flagged on one word");

    // Starting motion reports motion, ending it reports idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.started || result.ended) |-> result.motion == result.started)
        else $error("motion flag inconsistent with edge flags");

    // A waiting input word is held off only by a stalled, full result register.
    assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> in_valid_reg && out_valid_reg && result_stall)
        else $error("input stalled without a blocked result");

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the motion event tracker: directed table, then randomized phases.
module tb;
    import met_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned PHASES       = 7;
    localparam int unsigned PHASE_WORDS  = 86;
    localparam int unsigned DRAIN_CYCLES = 8;

    // Register settings and idle pressure per random phase; a negative debounce entry
    // means both registers take random values for that phase.
    localparam int          DBNC_SET [PHASES] = '{0, 65535, 30, 65535, 0, -1, -1};
    localparam int          HOLD_SET [PHASES] = '{0, 65535, 2500, 0, 65535, -1, -1};
    localparam int unsigned TX_IDLE  [PHASES] = '{0, 62, 0, 34, 62, 34, 0};
    localparam int unsigned RX_STALL [PHASES] = '{0, 0, 62, 34, 0, 34, 62};

    typedef struct packed {
        sample_t word;
        logic    typed;
        result_t want;
    } stim_row_t;

    localparam result_t NO_RESULT = '0;

    // Reset settings apply here: debounce 30 ms, hold-off 2500 ms.
    localparam stim_row_t DIRECTED_ROWS [18] = '{
        '{'{MODE_SAMPLE,      1'b0, 32'd0},          1'b1, NO_RESULT},
        '{'{MODE_CLEAR_STATS, 1'b1, 32'hFFFF_FFFF},  1'b1, NO_RESULT},
        '{'{MODE_SAMPLE,      1'b1, 32'd10},         1'b1, NO_RESULT},
        '{'{MODE_SAMPLE,      1'b1, 32'd40},         1'b1,
          '{1'b1, 1'b1, 1'b0, 32'd40, 32'd1, 32'd0, 32'd40, 32'd0}},
        '{'{MODE_SAMPLE,      1'b1, 32'd100},        1'b1,
          '{1'b1, 1'b0, 1'b0, 32'd0, 32'd1, 32'd0, 32'd40, 32'd60}},
        '{'{MODE_SAMPLE,      1'b0, 32'd110},        1'b1,
          '{1'b1, 1'b0, 1'b0, 32'd0, 32'd1, 32'd0, 32'd40, 32'd70}},
        '{'{MODE_SAMPLE,      1'b0, 32'd140},        1'b1,
          '{1'b0, 1'b0, 1'b1, 32'd100, 32'd1, 32'd100, 32'd40, 32'd70}},
        '{'{MODE_SAMPLE,      1'b1, 32'd200},        1'b1,
          '{1'b0, 1'b0, 1'b0, 32'd0, 32'd1, 32'd100, 32'd40, 32'd70}},
        '{'{MODE_SAMPLE,      1'b1, 32'd2640},       1'b1,
          '{1'b1, 1'b1, 1'b0, 32'd2500, 32'd2, 32'd100, 32'd2540, 32'd0}},
        '{'{MODE_CLEAR_STATS, 1'b0, 32'd0},          1'b1,
          '{1'b1, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0}},
        '{'{MODE_SAMPLE,      1'b0, 32'hFFFF_FFF0},  1'b0, NO_RESULT},
        '{'{MODE_SAMPLE,      1'b1, 32'h0000_0010},  1'b0, NO_RESULT},
        '{'{MODE_SAMPLE,      1'b1, 32'h0000_09B4},  1'b0, NO_RESULT},
        '{'{MODE_SAMPLE,      1'b0, 32'hFFFF_FFFF},  1'b0, NO_RESULT},
        '{'{MODE_SAMPLE,      1'b1, 32'hFFFF_FFFF},  1'b0, NO_RESULT},
        '{'{MODE_SAMPLE,      1'b1, 32'h0000_001E},  1'b0, NO_RESULT},
        '{'{MODE_SAMPLE,      1'b1, 32'h0000_09C3},  1'b0, NO_RESULT},
        '{'{MODE_CLEAR_STATS, 1'b0, 32'h8000_0000},  1'b0, NO_RESULT}
    };

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = CFG_DEBOUNCE;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;
    logic                  sample_valid = 1'b0;
    logic                  sample_stall;
    sample_t               sample       = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    result_t               result;

    // Tracker state as this bench predicts it.
    logic [15:0] dbnc_ms         = DEBOUNCE_RESET;
    logic [15:0] hold_ms         = HOLDOFF_RESET;
    logic        lvl_stable      = 1'b0;
    logic [31:0] mark_ms         = '0;
    logic        acc_now         = 1'b0;
    logic        acc_prev        = 1'b0;
    logic [31:0] evt_count       = '0;
    logic [31:0] span_start_ms   = '0;
    logic [31:0] quiet_until_ms  = '0;
    logic [31:0] motion_total_ms = '0;
    logic [31:0] idle_total_ms   = '0;
    logic [31:0] live_span_ms    = '0;

    result_t     tracker_reports [$];
    int unsigned tx_idle_pct  = 0;
    int unsigned rx_stall_pct = 0;
    int unsigned cycle_count  = 0;
    int unsigned error_count  = 0;
    int unsigned words_sent   = 0;
    int unsigned clears_sent  = 0;
    int unsigned starts_seen  = 0;
    int unsigned ends_seen    = 0;

    motion_event_tracker_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic result_t track_sample(input sample_t w);
        result_t     r;
        logic [31:0] elapsed;
        r = '0;
        if (w.mode == MODE_CLEAR_STATS)
        begin
            evt_count       = '0;
            motion_total_ms = '0;
            idle_total_ms   = '0;
        end
        else
        begin
            acc_prev = acc_now;
            // Debounce: a changed level must have held since the last mark.
            if (w.raw_level != lvl_stable)
            begin
                elapsed = w.now_ms - mark_ms;
                if (elapsed >= {16'd0, dbnc_ms})
                begin
                    lvl_stable = w.raw_level;
                    mark_ms    = w.now_ms;
                end
            end
            else
            begin
                mark_ms = w.now_ms;
            end
            acc_now = lvl_stable;
            if (acc_now && !acc_prev)
            begin
                // The deadline compare is a plain unsigned one, blind to wrap.
                if (w.now_ms >= quiet_until_ms)
                begin
                    evt_count      = evt_count + 32'd1;
                    r.last_span_ms = w.now_ms - span_start_ms;
                    idle_total_ms  = idle_total_ms + r.last_span_ms;
                    span_start_ms  = w.now_ms;
                    r.started      = 1'b1;
                end
                else
                begin
                    acc_now = 1'b0;
                end
            end
            if (!acc_now && acc_prev)
            begin
                r.last_span_ms  = w.now_ms - span_start_ms;
                motion_total_ms = motion_total_ms + r.last_span_ms;
                quiet_until_ms  = w.now_ms + {16'd0, hold_ms};
                span_start_ms   = w.now_ms;
                r.ended         = 1'b1;
            end
            if (acc_now)
                live_span_ms = w.now_ms - span_start_ms;
        end
        r.motion         = acc_now;
        r.event_total    = evt_count;
        r.motion_sum_ms  = motion_total_ms;
        r.idle_sum_ms    = idle_total_ms;
        r.active_span_ms = live_span_ms;
        return r;
    endfunction

    task automatic check_report(input result_t got);
        result_t want;
        if (tracker_reports.size() == 0)
        begin
            $error("result word arrived with no expectation pending");
            error_count++;
            return;
        end
        want = tracker_reports.pop_front();
        if (got.motion !== want.motion)
        begin
            $error("motion: expected %0d, got %0d", want.motion, got.motion);
            error_count++;
        end
        if (got.started !== want.started)
        begin
            $error("started: expected %0d, got %0d", want.started, got.started);
            error_count++;
        end
        if (got.ended !== want.ended)
        begin
            $error("ended: expected %0d, got %0d", want.ended, got.ended);
            error_count++;
        end
        if (got.last_span_ms !== want.last_span_ms)
        begin
            $error("last_span_ms: expected %0d, got %0d", want.last_span_ms, got.last_span_ms);
            error_count++;
        end
        if (got.event_total !== want.event_total)
        begin
            $error("event_total: expected %0d, got %0d", want.event_total, got.event_total);
            error_count++;
        end
        if (got.motion_sum_ms !== want.motion_sum_ms)
        begin
            $error("motion_sum_ms: expected %0d, got %0d", want.motion_sum_ms,
                   got.motion_sum_ms);
            error_count++;
        end
        if (got.idle_sum_ms !== want.idle_sum_ms)
        begin
            $error("idle_sum_ms: expected %0d, got %0d", want.idle_sum_ms, got.idle_sum_ms);
            error_count++;
        end
        if (got.active_span_ms !== want.active_span_ms)
        begin
            $error("active_span_ms: expected %0d, got %0d", want.active_span_ms,
                   got.active_span_ms);
            error_count++;
        end
    endtask

    // Result side: random stall, and every word taken at an edge is checked.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            result_stall <= ($urandom_range(0, 99) < rx_stall_pct);
            if (result_valid && !result_stall)
            begin
                if (result.started)
                    starts_seen++;
                if (result.ended)
                    ends_seen++;
                check_report(result);
            end
        end
    end

    task automatic push_word(input sample_t w, input logic typed, input result_t typed_want);
        result_t predicted;
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= w;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        predicted = track_sample(w);
        tracker_reports.push_back(typed ? typed_want : predicted);
        words_sent++;
        if (w.mode == MODE_CLEAR_STATS)
            clears_sent++;
    endtask

    task automatic drain_reports();
        sample_valid <= 1'b0;
        while (tracker_reports.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_regs(input logic [15:0] dbnc, input logic [15:0] hold);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_DEBOUNCE;
        cfg_data  <= dbnc;
        @(posedge clk);
        cfg_index <= CFG_HOLDOFF;
        cfg_data  <= hold;
        @(posedge clk);
        cfg_we  <= 1'b0;
        dbnc_ms = dbnc;
        hold_ms = hold;
    endtask

    // Mostly a sensor that holds a level with short glitches and a clock that moves
    // forward; a few clear-stats words and random jumps mixed in.
    task automatic run_phase(input int unsigned count);
        sample_t     w;
        int unsigned pick;
        logic [31:0] t_ms;
        logic        level;
        level = 1'b0;
        if ($urandom_range(0, 1) == 1)
            t_ms = 32'hFFFF_FFFF - $urandom_range(0, 300000);
        else
            t_ms = $urandom;
        for (int unsigned i = 0; i < count; i++)
        begin
            pick        = $urandom_range(0, 99);
            w.mode      = MODE_SAMPLE;
            w.raw_level = 1'($urandom_range(0, 1));
            if (pick < 3)
            begin
                w.mode   = MODE_CLEAR_STATS;
                w.now_ms = $urandom;
            end
            else if (pick < 8)
            begin
                t_ms     = $urandom;
                w.now_ms = t_ms;
            end
            else
            begin
                if ($urandom_range(0, 99) < 15)
                    level = ~level;
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    t_ms = t_ms + $urandom_range(0, 32'(dbnc_ms) + 32'(dbnc_ms) / 2 + 8);
                else if (pick < 92)
                    t_ms = t_ms + $urandom_range(0, 32'(hold_ms) + 32'(dbnc_ms) + 50);
                else
                    t_ms = t_ms + $urandom_range(0, 200000);
                w.raw_level = ($urandom_range(0, 99) < 10) ? ~level : level;
                w.now_ms    = t_ms;
            end
            push_word(w, 1'b0, NO_RESULT);
        end
    endtask

    initial
    begin
        logic [15:0] dbnc;
        logic [15:0] hold;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (DIRECTED_ROWS[i])
            push_word(DIRECTED_ROWS[i].word, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
        for (int p = 0; p < PHASES; p++)
        begin
            // Registers only change once every pending word has come back.
            drain_reports();
            if (DBNC_SET[p] < 0)
            begin
                dbnc = 16'($urandom_range(0, 400));
                hold = 16'($urandom_range(0, 6000));
            end
            else
            begin
                dbnc = 16'(DBNC_SET[p]);
                hold = 16'(HOLD_SET[p]);
            end
            write_regs(dbnc, hold);
            tx_idle_pct  = TX_IDLE[p];
            rx_stall_pct = RX_STALL[p];
            run_phase(PHASE_WORDS);
        end
        drain_reports();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d sample words (%0d clear-stats) under %0d register settings.",
                 words_sent, clears_sent, PHASES + 1);
        $display("Saw %0d motion starts and %0d motion ends; %0d field mismatches.",
                 starts_seen, ends_seen, error_count);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/met_pkg.sv
hw/rtl/met_step.sv
hw/rtl/motion_event_tracker_unit.sv
tb/sv/tb.sv
